// ===== hw/rtl/tme_pkg.sv =====
// ----------------------------------------------------------------------------
// tme_pkg: shared types and constants of the ternary matrix-vector engine
// Function codes, default sizes and the controller/datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package tme_pkg;
  localparam int unsigned MaxRowsDef = 64;
  localparam int unsigned MaxColsDef = 256;
  localparam int unsigned WordBits   = 64;
  localparam logic [15:0] ScaleOne   = 16'd4096;

  localparam logic [2:0] FuncWrWeight = 3'd0;
  localparam logic [2:0] FuncRdWeight = 3'd1;
  localparam logic [2:0] FuncWrScale  = 3'd2;
  localparam logic [2:0] FuncWrVector = 3'd3;
  localparam logic [2:0] FuncCompute  = 3'd4;

  localparam logic CfgRows = 1'b0;
  localparam logic CfgCols = 1'b1;

  typedef struct packed {
    logic start;     // latch the request, launch its operation
    logic acc_en;    // accumulate the current column
    logic mul_en;    // form the scaled product
    logic fin_en;    // round, saturate, load the result register
  } tme_cmd_t;

  typedef struct packed {
    logic last_col;  // current column is the last in use
    logic clr_busy;  // storage clearing pass after reset still running
  } tme_sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tme_ctrl.sv =====
// ----------------------------------------------------------------------------
// tme_ctrl: request sequencer
// Accepts one request at a time and steps compute row over the columns.
// ----------------------------------------------------------------------------
`default_nettype none
module tme_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         req_valid_i,
  input  wire logic [2:0]   req_func_i,
  input  wire logic         row_ok_i,
  input  wire logic         res_busy_i,
  input  tme_pkg::tme_sts_t sts_i,
  output logic              req_ready_o,
  output tme_pkg::tme_cmd_t cmd_o
);
  typedef enum logic [2:0] {StIdle, StRead, StAcc, StMul, StFin} state_e;
  state_e state_q, state_d;
  logic fire;

  assign req_ready_o = (state_q == StIdle) && !res_busy_i && !sts_i.clr_busy;
  assign fire = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.start = fire;
    unique case (state_q)
      StIdle: begin
        if (fire) begin
          if (req_func_i == tme_pkg::FuncCompute && row_ok_i) state_d = StAcc;
          else if (req_func_i == tme_pkg::FuncRdWeight) state_d = StRead;
        end
      end
      StRead: begin
        // hold off requests until the read answer is loaded
        state_d = StIdle;
      end
      StAcc: begin
        cmd_o.acc_en = 1'b1;
        if (sts_i.last_col) state_d = StMul;
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d = StFin;
      end
      StFin: begin
        cmd_o.fin_en = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tme_dp.sv =====
// ----------------------------------------------------------------------------
// tme_dp: storage and arithmetic
// Weight planes, scales, vector, one-column accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module tme_dp #(
  parameter int unsigned MAX_ROWS = tme_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = tme_pkg::MaxColsDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i,
  input  wire logic [2:0]   func_i,
  input  wire logic [5:0]   row_i,
  input  wire logic [7:0]   col_i,
  input  wire logic [1:0]   wv_i,
  input  wire logic [15:0]  data_i,
  input  tme_pkg::tme_cmd_t cmd_i,
  output tme_pkg::tme_sts_t sts_o,
  output logic              row_ok_o,
  output logic              res_valid_o,
  input  wire logic         res_ready_i,
  output logic [35:0]       res_o
);
  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned SumW = ColW + 17;
  localparam int unsigned Cells = MAX_ROWS * MAX_COLS;
  localparam int unsigned CellW = $clog2(Cells);

  logic [6:0] rows_q;
  logic [8:0] cols_q;
  logic [1:0] wmem [Cells];  // {minus, plus}
  logic [15:0] smem [MAX_ROWS];
  logic [15:0] vmem [MAX_COLS];
  logic clr_busy_q;
  logic [CellW-1:0] clr_q;

  logic [5:0] row_r_q;
  logic row_ok_r_q;
  logic [ColW:0] cnt_q;
  logic [1:0] w_rd_q;
  logic [15:0] v_rd_q;
  logic [15:0] s_rd_q;
  logic rd_live_q;
  logic signed [SumW-1:0] sum_q;
  logic signed [SumW+15:0] prod_q;
  logic res_valid_q;
  logic [35:0] res_q;

  logic [31:0] eff_rows, eff_cols;
  logic row_ok, col_ok;
  logic [CellW-1:0] waddr, raddr;
  logic [ColW-1:0] rcol;
  logic wr_w, wr_v, wr_s, cmp_oor;
  logic [1:0] w_out;

  assign eff_rows = (32'(rows_q) < MAX_ROWS) ? 32'(rows_q) : MAX_ROWS;
  assign eff_cols = (32'(cols_q) < MAX_COLS) ? 32'(cols_q) : MAX_COLS;
  assign row_ok = 32'(row_i) < eff_rows;
  assign col_ok = 32'(col_i) < eff_cols;
  assign row_ok_o = row_ok;
  assign waddr = CellW'(32'(row_i) * MAX_COLS + 32'(col_i));
  assign rcol = cmd_i.start ? ColW'(col_i) : ColW'(cnt_q);
  assign raddr = cmd_i.start ? waddr : CellW'(32'(row_r_q) * MAX_COLS + 32'(rcol));
  assign sts_o.last_col = (32'(cnt_q) + 32'd1 >= eff_cols);
  assign sts_o.clr_busy = clr_busy_q;

  assign wr_w = cmd_i.start && func_i == tme_pkg::FuncWrWeight && row_ok && col_ok;
  assign wr_v = cmd_i.start && func_i == tme_pkg::FuncWrVector && col_ok;
  assign wr_s = cmd_i.start && func_i == tme_pkg::FuncWrScale && row_ok;
  assign cmp_oor = cmd_i.start && func_i == tme_pkg::FuncCompute && !row_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 7'd64;
      cols_q <= 9'd256;
      clr_busy_q <= 1'b1;
      clr_q <= '0;
      res_valid_q <= 1'b0;
      rd_live_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == tme_pkg::CfgRows) rows_q <= cfg_data_i[6:0];
        else cols_q <= cfg_data_i[8:0];
      end
      if (clr_busy_q) begin
        clr_q <= clr_q + CellW'(1);
        if (clr_q == CellW'(Cells - 1)) clr_busy_q <= 1'b0;
      end
      rd_live_q <= cmd_i.start && func_i == tme_pkg::FuncRdWeight;
      if (rd_live_q || cmp_oor || cmd_i.fin_en) res_valid_q <= 1'b1;
      else if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
    end
  end

  // Memories: one write port, one registered read port each. After reset a
  // clearing pass walks each weight address once, the others repeatedly.
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      wmem[clr_q] <= 2'b00;
      vmem[ColW'(clr_q)] <= '0;
      smem[RowW'(clr_q)] <= tme_pkg::ScaleOne;
    end else begin
      if (wr_w) wmem[waddr] <= {wv_i[1], ~wv_i[1] & wv_i[0]};
      if (wr_v) vmem[ColW'(col_i)] <= data_i;
      if (wr_s) smem[RowW'(row_i)] <= data_i;
    end
    w_rd_q <= wmem[raddr];
    v_rd_q <= vmem[rcol];
    s_rd_q <= smem[RowW'(row_r_q)];
  end

  logic signed [SumW-1:0] term;
  logic signed [SumW-1:0] sum_all;
  logic acc_live_q;
  logic signed [SumW+15:0] shifted;
  logic [31:0] sat;
  assign term = w_rd_q[0] ? SumW'($signed(v_rd_q)) :
                w_rd_q[1] ? -SumW'($signed(v_rd_q)) : '0;
  assign sum_all = acc_live_q ? sum_q + term : sum_q;
  assign shifted = prod_q >>> 12;
  assign sat = (shifted > $signed(34'sh07FFFFFFF)) ? 32'h7FFFFFFF :
               (shifted < -$signed(34'sh080000000)) ? 32'h80000000 : shifted[31:0];
  assign w_out = row_ok_r_q ? {w_rd_q[1], w_rd_q[1] | w_rd_q[0]} : 2'b00;

  // Column walk: the read issued in one cycle lands in the next, so the
  // accumulator adds behind the counter. Drop reads past the bound.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      row_r_q <= row_i;
      row_ok_r_q <= row_ok && col_ok;
      cnt_q <= '0;
      sum_q <= '0;
      acc_live_q <= 1'b0;
    end else begin
      if (cmd_i.acc_en) cnt_q <= cnt_q + (ColW+1)'(1);
      acc_live_q <= cmd_i.acc_en && (32'(cnt_q) < eff_cols);
      if (acc_live_q) sum_q <= sum_q + term;
    end
    if (cmd_i.mul_en) prod_q <= (SumW+16)'(sum_all) * (SumW+16)'($signed(s_rd_q));
    if (cmd_i.fin_en) res_q <= {1'b1, sat, 2'b00, 1'b1};
    else if (cmp_oor) res_q <= {1'b0, 32'd0, 2'b00, 1'b1};
    else if (rd_live_q) res_q <= {row_ok_r_q, 32'd0, w_out, 1'b0};
  end

  assign res_valid_o = res_valid_q;
  assign res_o = res_q;
endmodule
`default_nettype wire

// ===== hw/rtl/ternary_matvec_engine_unit.sv =====
// ----------------------------------------------------------------------------
// ternary_matvec_engine_unit: ternary weight matrix times vector engine
// Stores a ternary matrix, row scales and a vector; answers reads and rows.
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_axis   in   tuser: func[2:0]
//               tdata: row_index[5:0] col_index[13:6] weight_value[15:14]
//                      data_value[31:16]
// m_axis   out  tuser: result_kind[0]
//               tdata: weight_out[1:0] row_result[33:2] in_range[34], zero in [39:35]
// cfg      in   index 0 rows_in_use, 1 cols_in_use
//
// A write request frees the input again in the next cycle. A weight read
// registers the request, then loads its answer. Compute row accumulates
// min(cols_in_use, MAX_COLS) columns behind the memory read ports, then forms
// the scaled product, then rounds and saturates into the result register; an
// out-of-range row answers without a column walk. One request is in flight at
// a time; after a read or compute a new request waits until the answer is
// taken. Reset starts a clearing pass of all cells that stalls all requests.
`default_nettype none
module ternary_matvec_engine_unit #(
  parameter int unsigned MAX_ROWS = tme_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS = tme_pkg::MaxColsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // row_index, col_index, weight_value, data_value
  input  wire logic [2:0]  s_axis_tuser,   // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // weight_out, row_result, in_range
  output logic             m_axis_tuser,   // result_kind
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  tme_pkg::tme_cmd_t cmd;
  tme_pkg::tme_sts_t sts;
  logic row_ok, busy;
  logic [35:0] res;

  assign cfg_ready_o = 1'b1;
  // hold new requests while an answer waits
  assign busy = m_axis_tvalid;
  assign m_axis_tuser = res[0];
  assign m_axis_tdata = {5'd0, res[35:1]};

  tme_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i(s_axis_tvalid), .req_func_i(s_axis_tuser),
    .row_ok_i(row_ok), .res_busy_i(busy), .sts_i(sts),
    .req_ready_o(s_axis_tready), .cmd_o(cmd)
  );

  tme_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i),
    .cfg_data_i, .func_i(s_axis_tuser), .row_i(s_axis_tdata[5:0]),
    .col_i(s_axis_tdata[13:6]), .wv_i(s_axis_tdata[15:14]),
    .data_i(s_axis_tdata[31:16]), .cmd_i(cmd), .sts_o(sts), .row_ok_o(row_ok),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/tme_checker.sv =====
// ----------------------------------------------------------------------------
// tme_checker: port-level checks of the engine
// Watches handshakes and result format on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module tme_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result dropped while stalled");
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("request taken with result pending");
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[33:2] == 32'd0)
    else $error("read answer carries row data");
  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == 2'b00)
    else $error("row answer carries weight");
endmodule
bind ternary_matvec_engine_unit tme_checker u_chk (.*);
`default_nettype wire
